// ----- hw/rtl/sfgd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfgd_pkg
// Shared types, codes and helpers of the stroke font glyph decoder.
// ----------------------------------------------------------------------------
package sfgd_pkg;

	// field widths
	localparam int BYTE_W = 8;
	localparam int X_W    = 7;
	localparam int Y_W    = 10;
	localparam int OY_W   = 9;
	localparam int DIM_W  = 7;
	localparam int CODE_W = 8;
	localparam int KIND_W = 2;
	localparam int CIDX_W = 2;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// stroke byte fields
	localparam logic [BYTE_W-1:0] DELTA_MASK = 8'h7F;
	localparam logic [BYTE_W-1:0] DELTA_SIGN = 8'h40;

	// largest reported box dimension
	localparam int SPAN_MAX = 127;

	// reset value of the first character code
	localparam logic [CODE_W-1:0] FIRST_CODE_RESET = 8'd32;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_ASCENDER  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DESCENDER = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_FIRST     = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_MOVE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DRAW = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	// stroke opcodes
	typedef enum logic [1:0] {
		OP_STOP = 2'd0,
		OP_SCAN = 2'd1,
		OP_MOVE = 2'd2,
		OP_DRAW = 2'd3
	} op_t;

	// classified stroke word, as queued from front to back
	typedef struct packed {
		logic                  start;
		op_t                   op;
		logic signed [X_W-1:0] nx;
		logic signed [Y_W-1:0] ny;
	} entry_t;

	// live configuration seen by front and back
	typedef struct packed {
		logic signed [OY_W-1:0] origin_y;
		logic [CODE_W-1:0]      first_code;
	} cfg_t;

	// signed seven-bit delta of a stroke byte, widened to a y coordinate
	function automatic logic signed [Y_W-1:0] delta_y(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] m;
		m = b & DELTA_MASK;
		delta_y = {{(Y_W-X_W){(m & DELTA_SIGN) != '0}}, m[X_W-1:0]};
	endfunction

	// origin y widened to a y coordinate
	function automatic logic signed [Y_W-1:0] widen_oy(input logic signed [OY_W-1:0] oy);
		widen_oy = {{(Y_W-OY_W){oy[OY_W-1]}}, oy};
	endfunction

endpackage

// ----- hw/rtl/sfgd_if.sv -----
// ----------------------------------------------------------------------------
// sfgd_if
// Channel interfaces: stroke input, command output and register write.
// ----------------------------------------------------------------------------
interface sfgd_in_if;
	import sfgd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stroke_byte_a;
	logic [BYTE_W-1:0] stroke_byte_b;

	modport source (output valid, output stroke_byte_a, output stroke_byte_b, input ready);
	modport sink   (input valid, input stroke_byte_a, input stroke_byte_b, output ready);
endinterface

interface sfgd_out_if;
	import sfgd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     command_kind;
	logic signed [X_W-1:0] point_x;
	logic signed [Y_W-1:0] point_y;
	logic [DIM_W-1:0]      glyph_width;
	logic [DIM_W-1:0]      glyph_height;
	logic [CODE_W-1:0]     char_code;
	logic                  last_result;

	modport source (
		output valid, output command_kind, output point_x, output point_y,
		output glyph_width, output glyph_height, output char_code,
		output last_result, input ready
	);
	modport sink (
		input valid, input command_kind, input point_x, input point_y,
		input glyph_width, input glyph_height, input char_code,
		input last_result, output ready
	);
endinterface

interface sfgd_cfg_if;
	import sfgd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [BYTE_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/stroke_font_glyph_decoder.sv -----
// ----------------------------------------------------------------------------
// stroke_font_glyph_decoder
// Turns two-byte stroke words into move, draw and glyph-done commands.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  stroke_in  in   valid/ready   stroke_byte_a, stroke_byte_b
//  glyph_out  out  valid/ready   command_kind, point_x, point_y, glyph_width,
//                                glyph_height, char_code, last_result
//  cfg        in   valid/ready   index, data (always ready)
//
//  One stroke word per cycle while the queue has room; a word that opens a glyph
//  and carries a move, draw or stop gives two results through the output register.
//  A scan word inside a glyph gives no result and leaves the queue without waiting.
//  A word's results pass through the queue and then the output register.
//  A two-entry queue parts decode from execution; the output register parts
//  execution from the sink, so input fills the queue while a result waits.
//  Reset is asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module stroke_font_glyph_decoder (
	input  logic       clk,
	input  logic       arst_n,
	sfgd_in_if.sink    stroke_in,
	sfgd_out_if.source glyph_out,
	sfgd_cfg_if.sink   cfg
);
	import sfgd_pkg::*;

	cfg_t   cfg_live;
	logic   push_valid, push_ready;
	entry_t push_entry;
	logic   head_valid, pop;
	entry_t head;

	sfgd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg),
		.cfg    (cfg_live)
	);

	sfgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (stroke_in),
		.cfg        (cfg_live),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	sfgd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (head_valid),
		.pop_entry  (head),
		.pop        (pop)
	);

	sfgd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_live),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (glyph_out)
	);

endmodule

// ----- hw/rtl/sfgd_cfg.sv -----
// ----------------------------------------------------------------------------
// sfgd_cfg
// Register file for ascender, descender and first character code.
// ----------------------------------------------------------------------------
module sfgd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	sfgd_cfg_if.sink          cfg_ch,
	output sfgd_pkg::cfg_t    cfg
);
	import sfgd_pkg::*;

	logic signed [BYTE_W-1:0] asc_q;
	logic signed [BYTE_W-1:0] desc_q;
	logic [CODE_W-1:0]        first_q;

	// every write is taken at once
	assign cfg_ch.ready = 1'b1;

	// store a register on each transfer; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asc_q   <= '0;
			desc_q  <= '0;
			first_q <= FIRST_CODE_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				CFG_ASCENDER:  asc_q   <= cfg_ch.data;
				CFG_DESCENDER: desc_q  <= cfg_ch.data;
				CFG_FIRST:     first_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// origin height: ascender minus descender
	assign cfg.origin_y   = {asc_q[BYTE_W-1], asc_q} - {desc_q[BYTE_W-1], desc_q};
	assign cfg.first_code = first_q;

endmodule

// ----- hw/rtl/sfgd_front.sv -----
// ----------------------------------------------------------------------------
// sfgd_front
// Accepts stroke words, decodes opcode and target point, marks glyph starts.
// ----------------------------------------------------------------------------
module sfgd_front (
	input  logic              clk,
	input  logic              arst_n,
	sfgd_in_if.sink           in_ch,
	input  sfgd_pkg::cfg_t    cfg,
	input  logic              push_ready,
	output logic              push_valid,
	output sfgd_pkg::entry_t  push_entry
);
	import sfgd_pkg::*;

	logic open_q;
	logic accept;
	op_t  op;

	assign push_valid  = in_ch.valid;
	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;

	// decode the word
	assign op               = op_t'({in_ch.stroke_byte_a[BYTE_W-1], in_ch.stroke_byte_b[BYTE_W-1]});
	assign push_entry.start = !open_q;
	assign push_entry.op    = op;
	assign push_entry.nx    = in_ch.stroke_byte_a[X_W-1:0];
	assign push_entry.ny    = widen_oy(cfg.origin_y) - delta_y(in_ch.stroke_byte_b);

	// track glyph boundaries: any word opens, a stop closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			open_q <= (op != OP_STOP);
		end
	end

endmodule

// ----- hw/rtl/sfgd_queue.sv -----
// ----------------------------------------------------------------------------
// sfgd_queue
// Short FIFO of decoded stroke words between front and back.
// ----------------------------------------------------------------------------
module sfgd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  sfgd_pkg::entry_t  push_entry,
	output logic              push_ready,
	output logic              pop_valid,
	output sfgd_pkg::entry_t  pop_entry,
	input  logic              pop
);
	import sfgd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// store payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- hw/rtl/sfgd_back.sv -----
// ----------------------------------------------------------------------------
// sfgd_back
// Executes queued stroke words: pen, bounding box, glyph count, results.
// ----------------------------------------------------------------------------
module sfgd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfgd_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  sfgd_pkg::entry_t  head,
	output logic              pop,
	sfgd_out_if.source        out_ch
);
	import sfgd_pkg::*;

	// glyph state
	logic                  phase_q;
	logic signed [X_W-1:0] pen_x_q;
	logic signed [Y_W-1:0] pen_y_q;
	logic signed [X_W-1:0] min_x_q, max_x_q;
	logic signed [Y_W-1:0] min_y_q, max_y_q;
	logic                  box_valid_q;
	logic [CODE_W-1:0]     index_q;

	// output register
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic signed [X_W-1:0] px_q;
	logic signed [Y_W-1:0] py_q;
	logic [DIM_W-1:0]      w_q, h_q;
	logic [CODE_W-1:0]     code_q;
	logic                  last_q;

	// control
	logic need_start, has_own, emits, slot_free, load, skip, first_of_two;

	// next result
	logic [KIND_W-1:0]     kind_d;
	logic signed [X_W-1:0] px_d;
	logic signed [Y_W-1:0] py_d;
	logic [DIM_W-1:0]      w_d, h_d;

	// box arithmetic
	logic signed [X_W-1:0] lx, hx;
	logic signed [Y_W-1:0] ly, hy;
	logic [X_W:0]          span_x;
	logic [Y_W:0]          span_y;
	logic [DIM_W-1:0]      dim_x, dim_y;
	logic signed [Y_W-1:0] origin_y;

	assign origin_y = widen_oy(cfg.origin_y);

	// sequence the one or two results of the head word
	assign need_start   = head.start && !phase_q;
	assign has_own      = (head.op != OP_SCAN);
	assign emits        = need_start || has_own;
	assign slot_free    = !out_valid_q || out_ch.ready;
	assign load         = head_valid && emits && slot_free;
	assign skip         = head_valid && !emits;
	assign first_of_two = need_start && has_own;
	assign pop          = skip || (load && !first_of_two);

	// segment extent against the pen
	assign lx = (pen_x_q < head.nx) ? pen_x_q : head.nx;
	assign hx = (pen_x_q < head.nx) ? head.nx : pen_x_q;
	assign ly = (pen_y_q < head.ny) ? pen_y_q : head.ny;
	assign hy = (pen_y_q < head.ny) ? head.ny : pen_y_q;

	// box size, saturated
	assign span_x = {max_x_q[X_W-1], max_x_q} - {min_x_q[X_W-1], min_x_q};
	assign span_y = {max_y_q[Y_W-1], max_y_q} - {min_y_q[Y_W-1], min_y_q};
	assign dim_x  = (span_x > (X_W+1)'(SPAN_MAX)) ? DIM_W'(SPAN_MAX) : span_x[DIM_W-1:0];
	assign dim_y  = (span_y > (Y_W+1)'(SPAN_MAX)) ? DIM_W'(SPAN_MAX) : span_y[DIM_W-1:0];

	// select the result
	always_comb begin
		kind_d = KIND_MOVE;
		px_d   = '0;
		py_d   = '0;
		w_d    = '0;
		h_d    = '0;
		if (need_start) begin
			py_d = origin_y;
		end else begin
			unique case (head.op)
				OP_MOVE: begin
					px_d = head.nx;
					py_d = head.ny;
				end
				OP_DRAW: begin
					kind_d = KIND_DRAW;
					px_d   = head.nx;
					py_d   = head.ny;
				end
				OP_STOP: begin
					kind_d = KIND_DONE;
					w_d    = box_valid_q ? dim_x : '0;
					h_d    = box_valid_q ? dim_y : '0;
				end
				OP_SCAN: ;
			endcase
		end
	end

	// update glyph state on each loaded result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			box_valid_q <= 1'b0;
			index_q     <= '0;
		end else if (load) begin
			if (need_start) begin
				phase_q     <= first_of_two;
				pen_x_q     <= '0;
				pen_y_q     <= origin_y;
				box_valid_q <= 1'b0;
			end else begin
				phase_q <= 1'b0;
				unique case (head.op)
					OP_MOVE: begin
						pen_x_q <= head.nx;
						pen_y_q <= head.ny;
					end
					OP_DRAW: begin
						pen_x_q     <= head.nx;
						pen_y_q     <= head.ny;
						box_valid_q <= 1'b1;
						if (!box_valid_q || lx < min_x_q) min_x_q <= lx;
						if (!box_valid_q || hx > max_x_q) max_x_q <= hx;
						if (!box_valid_q || ly < min_y_q) min_y_q <= ly;
						if (!box_valid_q || hy > max_y_q) max_y_q <= hy;
					end
					OP_STOP: begin
						index_q     <= index_q + CODE_W'(1);
						box_valid_q <= 1'b0;
					end
					OP_SCAN: ;
				endcase
			end
		end
	end

	// output valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			px_q   <= px_d;
			py_q   <= py_d;
			w_q    <= w_d;
			h_q    <= h_d;
			code_q <= cfg.first_code + index_q;
			last_q <= !first_of_two;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.command_kind = kind_q;
	assign out_ch.point_x      = px_q;
	assign out_ch.point_y      = py_q;
	assign out_ch.glyph_width  = w_q;
	assign out_ch.glyph_height = h_q;
	assign out_ch.char_code    = code_q;
	assign out_ch.last_result  = last_q;

`ifndef SYNTHESIS
	// a pending second result keeps its word at the queue head
	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid)
		else $error("second result pending without a queued word");

	// the origin move of a two-result word is never marked last
	a_start_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && first_of_two |=> phase_q && out_ch.command_kind == KIND_MOVE
			&& !out_ch.last_result)
		else $error("glyph start move sequenced wrongly");

	// a glyph start puts the pen on the origin and empties the box
	a_start_pen: assert property (@(posedge clk) disable iff (!arst_n)
		load && need_start |=> pen_x_q == '0 && !box_valid_q)
		else $error("glyph start did not reset pen and box");

	// a stop advances the glyph count by one and empties the box
	a_stop_count: assert property (@(posedge clk) disable iff (!arst_n)
		load && !need_start && head.op == OP_STOP
			|=> index_q == $past(index_q) + CODE_W'(1) && !box_valid_q)
		else $error("stop did not advance glyph count");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stroke font glyph decoder. A queue of stroke
// words feeds a steady or bursty driver; every accepted word runs through a local
// decoder model whose commands wait in order for the output monitor, which
// compares them field by field. Directed glyphs cover the opcode and range
// corners, then randomized glyphs run under several register settings and
// receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import sfgd_pkg::*;

	localparam int WORDS_PER_PHASE = 315;
	localparam int PHASES          = 6;
	localparam int HOLD_CYCLES     = 80;
	localparam int SETTLE_CYCLES   = 8;
	localparam int STALL_LIMIT     = 2000;

	// receiver and sender pacing modes
	localparam int RX_ALWAYS  = 0;
	localparam int RX_HALF    = 1;
	localparam int RX_SPARSE  = 2;
	localparam int RX_PATTERN = 3;
	localparam int TX_STEADY  = 0;
	localparam int TX_BURSTY  = 1;

	typedef struct packed {
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] b;
	} stroke_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic signed [X_W-1:0] px;
		logic signed [Y_W-1:0] py;
		logic [DIM_W-1:0]      w;
		logic [DIM_W-1:0]      h;
		logic [CODE_W-1:0]     code;
		logic                  last;
	} glyph_cmd_t;

	logic clk;
	logic arst_n;

	sfgd_in_if  in_ch ();
	sfgd_out_if out_ch ();
	sfgd_cfg_if cfg_ch ();

	stroke_font_glyph_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.stroke_in (in_ch),
		.glyph_out (out_ch),
		.cfg       (cfg_ch)
	);

	stroke_t    stroke_queue[$];
	glyph_cmd_t cmd_due[$];
	glyph_cmd_t want_cmd;

	// decoder model: registers and glyph state
	int                asc_off;
	int                desc_off;
	logic [CODE_W-1:0] first_code;
	bit                glyph_open_m;
	int                pen_x_m;
	int                pen_y_m;
	int                box_lo_x;
	int                box_hi_x;
	int                box_lo_y;
	int                box_hi_y;
	bit                box_seen;
	logic [CODE_W-1:0] glyph_count;

	int       err_count;
	int       idle_cycles;
	int       tx_mode;
	int       rx_mode;
	logic [7:0] rx_pattern;
	int       stall_asks;
	int       stall_taken;
	int       hold_left;
	int       burst_left;
	int       gap_left;
	bit       word_taken;

	// build one expected command from the current glyph state
	function automatic glyph_cmd_t form_cmd(input logic [KIND_W-1:0] kind,
			input int px, input int py, input int w, input int h);
		glyph_cmd_t c;
		c.kind = kind;
		c.px   = px[X_W-1:0];
		c.py   = py[Y_W-1:0];
		c.w    = w[DIM_W-1:0];
		c.h    = h[DIM_W-1:0];
		c.code = first_code + glyph_count;
		c.last = 1'b0;
		return c;
	endfunction

	function automatic int clip_span(input int lo, input int hi);
		int d;
		d = hi - lo;
		return (d > SPAN_MAX) ? SPAN_MAX : d;
	endfunction

	// decode one accepted stroke word and queue the commands it yields
	task automatic decode_stroke(input stroke_t s);
		op_t        op;
		int         oy;
		int         nx;
		int         ny;
		int         lx;
		int         hx;
		int         ly;
		int         hy;
		glyph_cmd_t outs[$];
		op = op_t'({s.a[BYTE_W-1], s.b[BYTE_W-1]});
		oy = asc_off - desc_off;
		// open a glyph with a move to the origin
		if (!glyph_open_m) begin
			glyph_open_m = 1'b1;
			pen_x_m      = 0;
			pen_y_m      = oy;
			box_seen     = 1'b0;
			outs.push_back(form_cmd(KIND_MOVE, 0, oy, 0, 0));
		end
		if (op == OP_MOVE || op == OP_DRAW) begin
			nx = $signed(s.a[X_W-1:0]);
			ny = oy - $signed(s.b[X_W-1:0]);
			// widen the box over pen and target
			if (op == OP_DRAW) begin
				lx = (pen_x_m < nx) ? pen_x_m : nx;
				hx = (pen_x_m < nx) ? nx : pen_x_m;
				ly = (pen_y_m < ny) ? pen_y_m : ny;
				hy = (pen_y_m < ny) ? ny : pen_y_m;
				if (!box_seen) begin
					box_lo_x = lx;
					box_hi_x = hx;
					box_lo_y = ly;
					box_hi_y = hy;
					box_seen = 1'b1;
				end else begin
					if (lx < box_lo_x) box_lo_x = lx;
					if (hx > box_hi_x) box_hi_x = hx;
					if (ly < box_lo_y) box_lo_y = ly;
					if (hy > box_hi_y) box_hi_y = hy;
				end
			end
			outs.push_back(form_cmd((op == OP_DRAW) ? KIND_DRAW : KIND_MOVE, nx, ny, 0, 0));
			pen_x_m = nx;
			pen_y_m = ny;
		end else if (op == OP_STOP) begin
			outs.push_back(form_cmd(KIND_DONE, 0, 0,
				box_seen ? clip_span(box_lo_x, box_hi_x) : 0,
				box_seen ? clip_span(box_lo_y, box_hi_y) : 0));
			glyph_count  = glyph_count + 1'b1;
			glyph_open_m = 1'b0;
			box_seen     = 1'b0;
		end
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			cmd_due.push_back(outs[i]);
	endtask

	function automatic stroke_t stroke_word(input op_t op, input logic [X_W-1:0] dx,
			input logic [X_W-1:0] dy);
		return {op[1], dx, op[0], dy};
	endfunction

	// deltas lean toward the signed extremes
	function automatic logic [X_W-1:0] rand_delta();
		case ($urandom_range(0, 5))
			0: return 7'h40;
			1: return 7'h3F;
			default: return X_W'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_offset();
		case ($urandom_range(0, 3))
			0: return 8'h80;
			1: return 8'h7F;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// queue one glyph of random strokes, closed by a stop unless told otherwise
	task automatic add_glyph(inout int count, input bit close);
		int      n;
		int      pick;
		stroke_t s;
		n = $urandom_range(0, 8);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				s = stroke_t'(16'($urandom_range(0, 16'hFFFF)));
			else if (pick < 25)
				s = stroke_word(OP_SCAN, X_W'($urandom_range(0, 127)),
					X_W'($urandom_range(0, 127)));
			else if (pick < 50)
				s = stroke_word(OP_MOVE, rand_delta(), rand_delta());
			else
				s = stroke_word(OP_DRAW, rand_delta(), rand_delta());
			stroke_queue.push_back(s);
			count++;
		end
		if (close) begin
			stroke_queue.push_back(stroke_word(OP_STOP, X_W'($urandom_range(0, 127)),
				X_W'($urandom_range(0, 127))));
			count++;
		end
	endtask

	// write one register while the decoder is idle, then mirror it
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_ASCENDER:  asc_off = $signed(val);
			CFG_DESCENDER: desc_off = $signed(val);
			CFG_FIRST:     first_code = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// wait until every word is taken and every command has come back
	task automatic settle();
		while (stroke_queue.size() != 0 || cmd_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [Y_W-1:0] want,
			input logic [Y_W-1:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: advance on each transfer, hold an offered word until taken
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			decode_stroke(stroke_queue.pop_front());
			word_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!(in_ch.valid && !word_taken)) begin
			word_taken = 1'b0;
			if (stroke_queue.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (tx_mode == TX_BURSTY && gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else begin
				in_ch.valid         <= 1'b1;
				in_ch.stroke_byte_a <= stroke_queue[0].a;
				in_ch.stroke_byte_b <= stroke_queue[0].b;
				if (tx_mode == TX_BURSTY) begin
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = $urandom_range(1, 7);
					end
				end
			end
		end
	end

	// receiver: long hold-offs on request, otherwise the phase's stall pattern
	always @(negedge clk) begin
		if (stall_taken != stall_asks) begin
			hold_left = HOLD_CYCLES;
			stall_taken++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ch.ready <= 1'b1;
				RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: begin
					out_ch.ready <= rx_pattern[0];
					rx_pattern   <= {rx_pattern[0], rx_pattern[7:1]};
				end
			endcase
		end
	end

	// monitor: compare each command transfer with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cmd_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected command, expected none, got kind %0d",
					$time, out_ch.command_kind);
			end else begin
				want_cmd = cmd_due.pop_front();
				check_field("command_kind", Y_W'(want_cmd.kind), Y_W'(out_ch.command_kind));
				check_field("point_x", Y_W'(want_cmd.px), Y_W'(out_ch.point_x));
				check_field("point_y", want_cmd.py, out_ch.point_y);
				check_field("glyph_width", Y_W'(want_cmd.w), Y_W'(out_ch.glyph_width));
				check_field("glyph_height", Y_W'(want_cmd.h), Y_W'(out_ch.glyph_height));
				check_field("char_code", Y_W'(want_cmd.code), Y_W'(out_ch.char_code));
				check_field("last_result", Y_W'(want_cmd.last), Y_W'(out_ch.last_result));
			end
		end
	end

	// watchdog: end the run when no channel transfers for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// stimulus
	initial begin
		int phase_no;
		int count;
		arst_n              = 1'b0;
		in_ch.valid         = 1'b0;
		in_ch.stroke_byte_a = '0;
		in_ch.stroke_byte_b = '0;
		out_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = CFG_ASCENDER;
		cfg_ch.data         = '0;
		asc_off             = 0;
		desc_off            = 0;
		first_code          = FIRST_CODE_RESET;
		glyph_open_m        = 1'b0;
		pen_x_m             = 0;
		pen_y_m             = 0;
		box_lo_x            = 0;
		box_hi_x            = 0;
		box_lo_y            = 0;
		box_hi_y            = 0;
		box_seen            = 1'b0;
		glyph_count         = '0;
		err_count           = 0;
		idle_cycles         = 0;
		tx_mode             = TX_STEADY;
		rx_mode             = RX_HALF;
		rx_pattern          = 8'b1011_0010;
		stall_asks          = 0;
		stall_taken         = 0;
		hold_left           = 0;
		burst_left          = 1;
		gap_left            = 0;
		word_taken          = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stop as the first word: empty glyph of size zero
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h00, 7'h00));
		// scan opens a glyph, scan inside gives nothing, full-range box
		stroke_queue.push_back(stroke_word(OP_SCAN, 7'h55, 7'h2A));
		stroke_queue.push_back(stroke_word(OP_SCAN, 7'h2A, 7'h55));
		stroke_queue.push_back(stroke_word(OP_MOVE, 7'h40, 7'h3F));
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h3F, 7'h40));
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h00, 7'h00));
		stroke_queue.push_back(stroke_word(OP_SCAN, 7'h7F, 7'h7F));
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h7F, 7'h7F));
		// move only: no draw, size zero
		stroke_queue.push_back(stroke_word(OP_MOVE, 7'h7F, 7'h7F));
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h40, 7'h40));
		// draw as the first word
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h3F, 7'h3F));
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h40, 7'h00));
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h01, 7'h01));
		settle();

		// widest positive origin, code wrap
		write_reg(CFG_ASCENDER, 8'h7F);
		write_reg(CFG_DESCENDER, 8'h80);
		write_reg(CFG_FIRST, 8'hFF);
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h00, 7'h40));
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h7F, 7'h3F));
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h00, 7'h00));
		stroke_queue.push_back(stroke_word(OP_MOVE, 7'h05, 7'h05));
		settle();

		// flip the origin inside an open glyph so the box saturates
		write_reg(CFG_ASCENDER, 8'h80);
		write_reg(CFG_DESCENDER, 8'h7F);
		write_reg(CFG_FIRST, 8'h00);
		stroke_queue.push_back(stroke_word(OP_DRAW, 7'h00, 7'h3F));
		stroke_queue.push_back(stroke_word(OP_STOP, 7'h00, 7'h00));
		settle();

		// random glyphs under varied settings and pacing
		for (phase_no = 0; phase_no < PHASES; phase_no++) begin
			tx_mode    = (phase_no == 0) ? TX_STEADY : TX_BURSTY;
			rx_mode    = (phase_no == 0) ? RX_ALWAYS : $urandom_range(RX_HALF, RX_PATTERN);
			rx_pattern = 8'($urandom_range(1, 254));
			write_reg(CFG_ASCENDER, pick_offset());
			write_reg(CFG_DESCENDER, pick_offset());
			write_reg(CFG_FIRST, (phase_no == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
			count = 0;
			while (count < WORDS_PER_PHASE)
				add_glyph(count, $urandom_range(0, 9) != 0);
			// leave a glyph open across the next register change
			if (phase_no % 2 == 1)
				stroke_queue.push_back(stroke_word(OP_MOVE, rand_delta(), rand_delta()));
			// stall the receiver while the sender keeps offering
			if (phase_no == 2 || phase_no == 4)
				stall_asks++;
			settle();
		end

		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
